[sv/mlp_pkg.sv]
// ----------------------------------------------------------------------------
// mlp_pkg
// Shared types, codes and the sigmoid table of the dense network evaluator.
// ----------------------------------------------------------------------------
package mlp_pkg;

  localparam int ACC_W = 56;

  localparam logic [1:0] ACT_WEIGHT  = 2'd0;
  localparam logic [1:0] ACT_BIAS    = 2'd1;
  localparam logic [1:0] ACT_FEATURE = 2'd2;

  localparam logic [1:0] LAYER_FIRST  = 2'd0;
  localparam logic [1:0] LAYER_SECOND = 2'd1;
  localparam logic [1:0] LAYER_OUTPUT = 2'd2;

  localparam logic [1:0] CFG_INPUT_COUNT  = 2'd0;
  localparam logic [1:0] CFG_FIRST_COUNT  = 2'd1;
  localparam logic [1:0] CFG_SECOND_COUNT = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [1:0]         layer;
    logic [4:0]         row;
    logic [4:0]         column;
    logic signed [31:0] value;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [15:0] probability;
    logic        saturated;
  } result_t;

  // command from controller to datapath
  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last;
    logic       clear;
    logic       sig_go;
    logic [1:0] layer;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic res_valid;
  } stat_t;

  // round(65536*sigmoid(k/2))
  function automatic logic [15:0] sig_lut(input logic [4:0] k);
    logic [15:0] v;
    case (k)
      5'd0:    v = 16'd32768;
      5'd1:    v = 16'd40793;
      5'd2:    v = 16'd47911;
      5'd3:    v = 16'd53581;
      5'd4:    v = 16'd57724;
      5'd5:    v = 16'd60565;
      5'd6:    v = 16'd62428;
      5'd7:    v = 16'd63615;
      5'd8:    v = 16'd64357;
      5'd9:    v = 16'd64816;
      5'd10:   v = 16'd65097;
      5'd11:   v = 16'd65269;
      5'd12:   v = 16'd65374;
      5'd13:   v = 16'd65438;
      5'd14:   v = 16'd65476;
      5'd15:   v = 16'd65500;
      default: v = 16'd65514;
    endcase
    return v;
  endfunction

endpackage

[sv/mlp_ctrl.sv]
// ----------------------------------------------------------------------------
// mlp_ctrl
// Sequencer: walks units and inputs of each layer, then starts the sigmoid.
// ----------------------------------------------------------------------------
module mlp_ctrl #(
  parameter int MAX_INPUTS        = 8,
  parameter int MAX_FIRST_HIDDEN  = 32,
  parameter int MAX_SECOND_HIDDEN = 32,
  localparam int MAXH  = (MAX_FIRST_HIDDEN > MAX_SECOND_HIDDEN) ?
                         MAX_FIRST_HIDDEN : MAX_SECOND_HIDDEN,
  localparam int MAXA  = (MAX_INPUTS > MAXH) ? MAX_INPUTS : MAXH,
  localparam int IDXW  = (MAXA > 1) ? $clog2(MAXA) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  logic [3:0]        cnt0_i,
  input  logic [5:0]        cnt1_i,
  input  logic [5:0]        cnt2_i,
  input  mlp_pkg::stat_t    stat_i,
  output mlp_pkg::cmd_t     cmd_o,
  output logic [IDXW-1:0]   row_o,
  output logic [IDXW-1:0]   col_o,
  output logic              busy_o
);
  import mlp_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_DRAIN, S_SIG} state_e;

  state_e          state_q;
  logic [1:0]      layer_q;
  logic [IDXW-1:0] i_q, j_q;
  cmd_t            cmd_q;
  logic [IDXW-1:0] row_q, col_q;

  logic [31:0]     lim0, lim1, lim2;
  logic [IDXW-1:0] i_lim, j_lim;

  // last index of each layer, register value clamped to 1..max
  always_comb begin
    if (cnt0_i == '0) lim0 = '0;
    else if (32'(cnt0_i) > 32'(MAX_INPUTS)) lim0 = 32'(MAX_INPUTS - 1);
    else lim0 = 32'(cnt0_i) - 32'd1;
    if (cnt1_i == '0) lim1 = '0;
    else if (32'(cnt1_i) > 32'(MAX_FIRST_HIDDEN)) lim1 = 32'(MAX_FIRST_HIDDEN - 1);
    else lim1 = 32'(cnt1_i) - 32'd1;
    if (cnt2_i == '0) lim2 = '0;
    else if (32'(cnt2_i) > 32'(MAX_SECOND_HIDDEN)) lim2 = 32'(MAX_SECOND_HIDDEN - 1);
    else lim2 = 32'(cnt2_i) - 32'd1;
    case (layer_q)
      LAYER_FIRST: begin
        j_lim = lim0[IDXW-1:0];
        i_lim = lim1[IDXW-1:0];
      end
      LAYER_SECOND: begin
        j_lim = lim1[IDXW-1:0];
        i_lim = lim2[IDXW-1:0];
      end
      default: begin
        j_lim = lim2[IDXW-1:0];
        i_lim = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      layer_q <= LAYER_FIRST;
      i_q     <= '0;
      j_q     <= '0;
      cmd_q   <= '0;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      cmd_q <= '0;
      case (state_q)
        S_IDLE: begin
          if (go_i) begin
            state_q     <= S_ISSUE;
            layer_q     <= LAYER_FIRST;
            i_q         <= '0;
            j_q         <= '0;
            cmd_q.clear <= 1'b1;
          end
        end
        S_ISSUE: begin
          cmd_q.valid <= 1'b1;
          cmd_q.first <= (j_q == '0);
          cmd_q.last  <= (j_q == j_lim);
          cmd_q.layer <= layer_q;
          row_q       <= i_q;
          col_q       <= j_q;
          if (j_q == j_lim) begin
            j_q <= '0;
            if (i_q == i_lim) state_q <= S_DRAIN;
            else i_q <= i_q + 1'b1;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!stat_i.pipe_busy) begin
            if (layer_q == LAYER_OUTPUT) begin
              state_q      <= S_SIG;
              cmd_q.sig_go <= 1'b1;
            end else begin
              state_q <= S_ISSUE;
              layer_q <= layer_q + 2'd1;
              i_q     <= '0;
              j_q     <= '0;
            end
          end
        end
        S_SIG: begin
          if (stat_i.res_valid) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cmd_o  = cmd_q;
  assign row_o  = row_q;
  assign col_o  = col_q;
  assign busy_o = (state_q != S_IDLE);

endmodule

[sv/mlp_datapath.sv]
// ----------------------------------------------------------------------------
// mlp_datapath
// Parameter stores, shared multiply-accumulate pipeline and sigmoid stages.
// ----------------------------------------------------------------------------
module mlp_datapath #(
  parameter int MAX_INPUTS        = 8,
  parameter int MAX_FIRST_HIDDEN  = 32,
  parameter int MAX_SECOND_HIDDEN = 32,
  localparam int MAXH  = (MAX_FIRST_HIDDEN > MAX_SECOND_HIDDEN) ?
                         MAX_FIRST_HIDDEN : MAX_SECOND_HIDDEN,
  localparam int MAXA  = (MAX_INPUTS > MAXH) ? MAX_INPUTS : MAXH,
  localparam int IDXW  = (MAXA > 1) ? $clog2(MAXA) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  mlp_pkg::item_t    item_i,
  input  mlp_pkg::cmd_t     cmd_i,
  input  logic [IDXW-1:0]   row_i,
  input  logic [IDXW-1:0]   col_i,
  output mlp_pkg::stat_t    stat_o,
  output logic              done_o,
  output mlp_pkg::result_t  result_o
);
  import mlp_pkg::*;

  localparam int W1D = MAX_FIRST_HIDDEN * MAX_INPUTS;
  localparam int W2D = MAX_SECOND_HIDDEN * MAX_FIRST_HIDDEN;
  localparam int A1W = (W1D > 1) ? $clog2(W1D) : 1;
  localparam int A2W = (W2D > 1) ? $clog2(W2D) : 1;
  localparam int NIW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int N1W = (MAX_FIRST_HIDDEN > 1) ? $clog2(MAX_FIRST_HIDDEN) : 1;
  localparam int N2W = (MAX_SECOND_HIDDEN > 1) ? $clog2(MAX_SECOND_HIDDEN) : 1;

  logic signed [31:0] w1_mem [W1D];
  logic signed [31:0] w2_mem [W2D];
  logic signed [31:0] wo_mem [MAX_SECOND_HIDDEN];
  logic signed [31:0] b1_mem [MAX_FIRST_HIDDEN];
  logic signed [31:0] b2_mem [MAX_SECOND_HIDDEN];
  logic signed [31:0] f_mem  [MAX_INPUTS];
  logic signed [31:0] a1_mem [MAX_FIRST_HIDDEN];
  logic signed [31:0] a2_mem [MAX_SECOND_HIDDEN];
  logic signed [31:0] ob_q;

  logic [31:0] wa1, wa2, ra1, ra2;
  logic        row_ok1, row_ok2, col_ok0, col_ok1, col_ok2;

  // stage 1: registered reads
  cmd_t               t1_q;
  logic [IDXW-1:0]    row1_q;
  logic signed [31:0] w1_q, w2_q, wo_q, b1_q, b2_q, f_q, a1_q, a2_q, obr_q;
  // stage 2: product
  cmd_t               t2_q;
  logic [IDXW-1:0]    row2_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] bias2_q;
  logic signed [31:0] op_a, op_w, op_b;
  // stage 3: accumulate
  logic signed [ACC_W-1:0] acc_q, sum;
  logic signed [31:0]      clip, relu_v, z_q;
  logic                    over, sat_q;

  // sigmoid stages
  logic               s1_q, s2_q, done_q;
  logic               neg1_q, big1_q, neg2_q, big2_q;
  logic [15:0]        t01_q, d1_q, t02_q;
  logic [14:0]        frac1_q;
  logic [30:0]        sp_q;
  logic signed [32:0] zx;
  logic [32:0]        mag;
  logic [3:0]         sidx;
  logic [16:0]        y;
  result_t            res_q;

  always_comb begin
    wa1     = 32'(item_i.row) * 32'(MAX_INPUTS) + 32'(item_i.column);
    wa2     = 32'(item_i.row) * 32'(MAX_FIRST_HIDDEN) + 32'(item_i.column);
    ra1     = 32'(row_i) * 32'(MAX_INPUTS) + 32'(col_i);
    ra2     = 32'(row_i) * 32'(MAX_FIRST_HIDDEN) + 32'(col_i);
    row_ok1 = 32'(item_i.row) < 32'(MAX_FIRST_HIDDEN);
    row_ok2 = 32'(item_i.row) < 32'(MAX_SECOND_HIDDEN);
    col_ok0 = 32'(item_i.column) < 32'(MAX_INPUTS);
    col_ok1 = 32'(item_i.column) < 32'(MAX_FIRST_HIDDEN);
    col_ok2 = 32'(item_i.column) < 32'(MAX_SECOND_HIDDEN);
  end

  always_comb begin
    case (t1_q.layer)
      LAYER_FIRST: begin
        op_a = f_q;
        op_w = w1_q;
        op_b = b1_q;
      end
      LAYER_SECOND: begin
        op_a = a1_q;
        op_w = w2_q;
        op_b = b2_q;
      end
      default: begin
        op_a = a2_q;
        op_w = wo_q;
        op_b = obr_q;
      end
    endcase
  end

  // floor shift of the product, then a wide add, then clip to q16.16
  always_comb begin
    sum  = (t2_q.first ? ACC_W'(bias2_q) : acc_q) + ACC_W'($signed(prod_q[63:16]));
    over = (sum[ACC_W-1:31] != '0) && (sum[ACC_W-1:31] != '1);
    if (!over) clip = sum[31:0];
    else if (sum[ACC_W-1]) clip = 32'sh8000_0000;
    else clip = 32'sh7fff_ffff;
    relu_v = clip[31] ? 32'sd0 : clip;
  end

  always_comb begin
    zx   = 33'(z_q);
    mag  = zx[32] ? 33'(-zx) : 33'(zx);
    sidx = mag[18:15];
    y    = 17'(t02_q) + 17'((sp_q + 31'd16384) >> 15);
    if (big2_q) y = 17'(sig_lut(5'd16));
    if (neg2_q) y = 17'd65536 - y;
    if (y > 17'd65535) y = 17'd65535;
  end

  // stores and payload registers
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      case (item_i.action)
        ACT_WEIGHT: begin
          if (item_i.layer == LAYER_FIRST && row_ok1 && col_ok0)
            w1_mem[wa1[A1W-1:0]] <= item_i.value;
          else if (item_i.layer == LAYER_SECOND && row_ok2 && col_ok1)
            w2_mem[wa2[A2W-1:0]] <= item_i.value;
          else if (item_i.layer == LAYER_OUTPUT && item_i.row == '0 && col_ok2)
            wo_mem[item_i.column[N2W-1:0]] <= item_i.value;
        end
        ACT_BIAS: begin
          if (item_i.layer == LAYER_FIRST && row_ok1)
            b1_mem[item_i.row[N1W-1:0]] <= item_i.value;
          else if (item_i.layer == LAYER_SECOND && row_ok2)
            b2_mem[item_i.row[N2W-1:0]] <= item_i.value;
          else if (item_i.layer == LAYER_OUTPUT && item_i.row == '0)
            ob_q <= item_i.value;
        end
        ACT_FEATURE: begin
          if (col_ok0) f_mem[item_i.column[NIW-1:0]] <= item_i.value;
        end
        default: ;
      endcase
    end

    w1_q   <= w1_mem[ra1[A1W-1:0]];
    w2_q   <= w2_mem[ra2[A2W-1:0]];
    wo_q   <= wo_mem[col_i[N2W-1:0]];
    b1_q   <= b1_mem[row_i[N1W-1:0]];
    b2_q   <= b2_mem[row_i[N2W-1:0]];
    obr_q  <= ob_q;
    f_q    <= f_mem[col_i[NIW-1:0]];
    a1_q   <= a1_mem[col_i[N1W-1:0]];
    a2_q   <= a2_mem[col_i[N2W-1:0]];
    row1_q <= row_i;

    prod_q  <= op_w * op_a;
    bias2_q <= op_b;
    row2_q  <= row1_q;

    if (t2_q.valid) begin
      acc_q <= sum;
      if (t2_q.last) begin
        case (t2_q.layer)
          LAYER_FIRST:  a1_mem[row2_q[N1W-1:0]] <= relu_v;
          LAYER_SECOND: a2_mem[row2_q[N2W-1:0]] <= relu_v;
          default:      z_q <= clip;
        endcase
      end
    end

    neg1_q  <= zx[32];
    big1_q  <= mag >= 33'h8_0000;
    t01_q   <= sig_lut({1'b0, sidx});
    d1_q    <= sig_lut({1'b0, sidx} + 5'd1) - sig_lut({1'b0, sidx});
    frac1_q <= mag[14:0];
    neg2_q  <= neg1_q;
    big2_q  <= big1_q;
    t02_q   <= t01_q;
    sp_q    <= 31'(d1_q) * 31'(frac1_q);
    res_q.probability <= y[15:0];
    res_q.saturated   <= sat_q;
  end

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q   <= '0;
      t2_q   <= '0;
      sat_q  <= 1'b0;
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      t1_q   <= cmd_i;
      t2_q   <= t1_q;
      s1_q   <= cmd_i.sig_go;
      s2_q   <= s1_q;
      done_q <= s2_q;
      if (cmd_i.clear) sat_q <= 1'b0;
      else if (t2_q.valid && t2_q.last && over) sat_q <= 1'b1;
    end
  end

  // a command still waiting at the input also counts as in flight
  assign stat_o.pipe_busy = cmd_i.valid | t1_q.valid | t2_q.valid;
  assign stat_o.res_valid = done_q;
  assign done_o           = done_q;
  assign result_o         = res_q;

endmodule

[sv/mlp_relu_sigmoid_inference.sv]
// ----------------------------------------------------------------------------
// mlp_relu_sigmoid_inference
// Dense network evaluator: two relu hidden layers and one sigmoid output.
// Weight, bias and plain feature items are written when start is high and busy is low.
// A feature item with last set starts an evaluation that gives its result;
// it runs one product per cycle within a layer through the single shared
// multiply-accumulate pipeline; busy stays high meanwhile.
// The result strobe lasts one cycle; the receiver cannot stall.
// Reset clears control and loads the counts 2, 32 and 32; stores hold no reset value.
// ----------------------------------------------------------------------------
module mlp_relu_sigmoid_inference #(
  parameter int MAX_INPUTS        = 8,
  parameter int MAX_FIRST_HIDDEN  = 32,
  parameter int MAX_SECOND_HIDDEN = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  mlp_pkg::item_t    item_i,
  output logic              done_o,
  output mlp_pkg::result_t  result_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [5:0]        cfg_data_i
);
  import mlp_pkg::*;

  localparam int MAXH  = (MAX_FIRST_HIDDEN > MAX_SECOND_HIDDEN) ?
                         MAX_FIRST_HIDDEN : MAX_SECOND_HIDDEN;
  localparam int MAXA  = (MAX_INPUTS > MAXH) ? MAX_INPUTS : MAXH;
  localparam int IDXW  = (MAXA > 1) ? $clog2(MAXA) : 1;

  logic [3:0]      cnt0_q;
  logic [5:0]      cnt1_q, cnt2_q;
  logic            accept, go;
  cmd_t            cmd;
  stat_t           stat;
  logic [IDXW-1:0] row, col;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt0_q <= 4'd2;
      cnt1_q <= 6'd32;
      cnt2_q <= 6'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INPUT_COUNT:  cnt0_q <= cfg_data_i[3:0];
        CFG_FIRST_COUNT:  cnt1_q <= cfg_data_i;
        CFG_SECOND_COUNT: cnt2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = start && !busy;
  assign go     = accept && (item_i.action == ACT_FEATURE) && item_i.last;

  mlp_ctrl #(
    .MAX_INPUTS        (MAX_INPUTS),
    .MAX_FIRST_HIDDEN  (MAX_FIRST_HIDDEN),
    .MAX_SECOND_HIDDEN (MAX_SECOND_HIDDEN)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .cnt0_i (cnt0_q),
    .cnt1_i (cnt1_q),
    .cnt2_i (cnt2_q),
    .stat_i (stat),
    .cmd_o  (cmd),
    .row_o  (row),
    .col_o  (col),
    .busy_o (busy)
  );

  mlp_datapath #(
    .MAX_INPUTS        (MAX_INPUTS),
    .MAX_FIRST_HIDDEN  (MAX_FIRST_HIDDEN),
    .MAX_SECOND_HIDDEN (MAX_SECOND_HIDDEN)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (accept),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .row_i    (row),
    .col_i    (col),
    .stat_o   (stat),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // a result only appears inside an evaluation
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe outside an evaluation");

  // one result per evaluation, then idle
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy))
    else $error("result strobe repeated or block stuck busy");

  // the last feature transfer starts an evaluation
  a_go_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> busy)
    else $error("evaluation did not start");

endmodule
